// ===== hw/rtl/dfp_pkg.sv =====
// dfp_pkg: shared types, codes and constants for the decimal field parser
// used by dfp_finish, dfp_field and decimal_field_parser_top; no dependencies
package dfp_pkg;

  // widths of the word fields
  localparam int CHAR_W      = 8;
  localparam int BOUND_W     = 33;
  localparam int MAG_W       = 32;
  localparam int VAL_W       = 33;
  localparam int CMP_W       = 34;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 40;

  // characters of interest
  localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
  localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_PLUS    = 8'h2b;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0a;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;

  // natural ranges of the two field kinds, in comparison width
  localparam logic signed [CMP_W-1:0] S32_MIN = -34'sd2147483648;
  localparam logic signed [CMP_W-1:0] S32_MAX = 34'sd2147483647;
  localparam logic signed [CMP_W-1:0] U32_MIN = 34'sd0;
  localparam logic signed [CMP_W-1:0] U32_MAX = 34'sd4294967295;

  // field kind carried in tuser
  localparam logic KIND_UNSIGNED = 1'b0;
  localparam logic KIND_SIGNED   = 1'b1;

  // fault held per field and per line
  typedef enum logic [1:0] {
    FLT_NONE      = 2'd0,
    FLT_NON_DIGIT = 2'd1,
    FLT_OVERFLOW  = 2'd2,
    FLT_RANGE     = 2'd3
  } fault_t;

  // status of a result word
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NON_DIGIT = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_RANGE     = 3'd3,
    ST_END_ONLY  = 3'd4
  } status_t;

  // state of the pending field and the line, handed to the finish logic
  typedef struct packed {
    logic             in_field;
    logic             is_negative;
    logic             digit_seen;
    logic [MAG_W-1:0] magnitude;
    fault_t           field_fault;
    fault_t           line_fault;
  } field_state_t;

  // one result record
  typedef struct packed {
    logic [VAL_W-1:0] field_value;
    status_t          status;
    logic             last_of_line;
  } record_t;

endpackage

// ===== hw/rtl/dfp_finish.sv =====
// dfp_finish: closes a pending field, range check and sticky line fault
// depends on dfp_pkg
module dfp_finish (
  input  dfp_pkg::field_state_t          st_i,
  input  logic                           kind_i,
  input  logic [dfp_pkg::BOUND_W-1:0]    lower_bound_i,
  input  logic [dfp_pkg::BOUND_W-1:0]    upper_bound_i,
  output logic [dfp_pkg::VAL_W-1:0]      field_value_o,
  output dfp_pkg::fault_t                status_o
);

  logic signed [dfp_pkg::CMP_W-1:0] mag_s;
  logic signed [dfp_pkg::CMP_W-1:0] val_s;
  logic signed [dfp_pkg::CMP_W-1:0] lo_s;
  logic signed [dfp_pkg::CMP_W-1:0] hi_s;
  logic signed [dfp_pkg::CMP_W-1:0] nat_lo;
  logic signed [dfp_pkg::CMP_W-1:0] nat_hi;
  logic                             out_of_range;
  dfp_pkg::fault_t                  fld_st;

  // signed value and bounds at comparison width
  assign mag_s  = $signed({2'b00, st_i.magnitude});
  assign val_s  = st_i.is_negative ? -mag_s : mag_s;
  assign lo_s   = $signed({lower_bound_i[dfp_pkg::BOUND_W-1], lower_bound_i});
  assign hi_s   = $signed({upper_bound_i[dfp_pkg::BOUND_W-1], upper_bound_i});
  assign nat_lo = (kind_i == dfp_pkg::KIND_SIGNED) ? dfp_pkg::S32_MIN : dfp_pkg::U32_MIN;
  assign nat_hi = (kind_i == dfp_pkg::KIND_SIGNED) ? dfp_pkg::S32_MAX : dfp_pkg::U32_MAX;

  assign out_of_range = (val_s < lo_s) || (val_s > hi_s) ||
                        (val_s < nat_lo) || (val_s > nat_hi);

  // first fault of the field, then a missing digit, then range
  always_comb begin
    if (st_i.field_fault != dfp_pkg::FLT_NONE) begin
      fld_st = st_i.field_fault;
    end else if (!st_i.digit_seen) begin
      fld_st = dfp_pkg::FLT_NON_DIGIT;
    end else if (out_of_range) begin
      fld_st = dfp_pkg::FLT_RANGE;
    end else begin
      fld_st = dfp_pkg::FLT_NONE;
    end
  end

  // an earlier fault of the line overrides
  assign status_o = (st_i.line_fault != dfp_pkg::FLT_NONE) ? st_i.line_fault : fld_st;

  assign field_value_o = (status_o == dfp_pkg::FLT_NONE) ?
                         val_s[dfp_pkg::VAL_W-1:0] : '0;

endmodule

// ===== hw/rtl/dfp_field.sv =====
// dfp_field: field and line state, digit accumulation and record forming
// depends on dfp_pkg and dfp_finish
module dfp_field (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step_i,
  input  logic [dfp_pkg::CHAR_W-1:0]   character_i,
  input  logic                         kind_i,
  input  logic [dfp_pkg::BOUND_W-1:0]  lower_bound_i,
  input  logic [dfp_pkg::BOUND_W-1:0]  upper_bound_i,
  output logic                         emit_o,
  output dfp_pkg::record_t             record_o
);

  dfp_pkg::field_state_t st_r, st_nxt;

  logic                      is_nl;
  logic                      is_sp;
  logic                      is_sign;
  logic                      is_digit;
  logic [dfp_pkg::MAG_W-1:0] eff_mag;
  dfp_pkg::fault_t           eff_fault;
  logic [dfp_pkg::MAG_W+3:0] next_mag;
  logic [dfp_pkg::VAL_W-1:0] fin_value;
  dfp_pkg::fault_t           fin_status;

  // character classes
  assign is_nl    = (character_i == dfp_pkg::CH_NEWLINE);
  assign is_sp    = (character_i == dfp_pkg::CH_SPACE);
  assign is_sign  = (character_i == dfp_pkg::CH_MINUS) || (character_i == dfp_pkg::CH_PLUS);
  assign is_digit = (character_i >= dfp_pkg::CH_ZERO) && (character_i <= dfp_pkg::CH_NINE);

  // a new field starts from a cleared accumulator
  assign eff_mag   = st_r.in_field ? st_r.magnitude : '0;
  assign eff_fault = st_r.in_field ? st_r.field_fault : dfp_pkg::FLT_NONE;

  // times ten plus digit, carried four bits wider to spot overflow
  assign next_mag = {1'b0, eff_mag, 3'b000} + {3'b000, eff_mag, 1'b0} +
                    {{dfp_pkg::MAG_W{1'b0}}, character_i[3:0]};

  dfp_finish u_finish (
    .st_i          (st_r),
    .kind_i        (kind_i),
    .lower_bound_i (lower_bound_i),
    .upper_bound_i (upper_bound_i),
    .field_value_o (fin_value),
    .status_o      (fin_status)
  );

  // record for a terminating character
  assign emit_o = is_nl || (is_sp && st_r.in_field);

  always_comb begin
    record_o.last_of_line = is_nl;
    if (is_nl && !st_r.in_field) begin
      record_o.field_value = '0;
      record_o.status      = dfp_pkg::ST_END_ONLY;
    end else begin
      record_o.field_value = fin_value;
      record_o.status      = dfp_pkg::status_t'({1'b0, fin_status});
    end
  end

  // state update for one word
  always_comb begin
    st_nxt = st_r;
    if (step_i) begin
      if (is_nl) begin
        st_nxt = '0;
      end else if (is_sp) begin
        if (st_r.in_field) begin
          st_nxt             = '0;
          st_nxt.line_fault  = (st_r.line_fault != dfp_pkg::FLT_NONE) ?
                               st_r.line_fault : fin_status;
        end
      end else begin
        st_nxt.in_field    = 1'b1;
        st_nxt.magnitude   = eff_mag;
        st_nxt.field_fault = eff_fault;
        if (!st_r.in_field) begin
          st_nxt.is_negative = 1'b0;
          st_nxt.digit_seen  = 1'b0;
        end
        if (!st_r.in_field && (kind_i == dfp_pkg::KIND_SIGNED) && is_sign) begin
          st_nxt.is_negative = (character_i == dfp_pkg::CH_MINUS);
        end else if (eff_fault != dfp_pkg::FLT_NONE) begin
          st_nxt.field_fault = eff_fault;
        end else if (!is_digit) begin
          st_nxt.field_fault = dfp_pkg::FLT_NON_DIGIT;
        end else if (next_mag[dfp_pkg::MAG_W+3:dfp_pkg::MAG_W] != 4'd0) begin
          st_nxt.field_fault = dfp_pkg::FLT_OVERFLOW;
        end else begin
          st_nxt.magnitude  = next_mag[dfp_pkg::MAG_W-1:0];
          st_nxt.digit_seen = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== hw/rtl/decimal_field_parser_top.sv =====
// decimal_field_parser_top: input word register, field logic, result register
// depends on dfp_pkg, dfp_field and dfp_finish
//
//  channel | dir | handshake          | content
//  in_     | in  | tvalid/tready      | tdata character, lower_bound, upper_bound; tuser field kind
//  out_    | out | tvalid/tready      | tdata field_value; tuser status; tlast last_of_line
//
// one input word per cycle sustained while the output is not stalled; a word is
// held in the input register, then its result in the result register after the field logic
// the multiply-by-ten, add and bound compare sit between those two registers
// a stalled result holds the result register and the word behind it; the
// input register still fills, so the input stalls one word later
// reset (rst_n low, synchronous) clears the line state and both valid flags
module decimal_field_parser_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [dfp_pkg::IN_TDATA_W-1:0]     in_tdata,   // character, lower_bound, upper_bound, zero pad
  input  logic                               in_tuser,   // field kind
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [dfp_pkg::OUT_TDATA_W-1:0]    out_tdata,  // field_value, zero pad
  output logic [2:0]                         out_tuser,  // status
  output logic                               out_tlast
);

  logic                        in_valid_r;
  logic [dfp_pkg::CHAR_W-1:0]  char_r;
  logic                        kind_r;
  logic [dfp_pkg::BOUND_W-1:0] lo_r;
  logic [dfp_pkg::BOUND_W-1:0] hi_r;
  logic                        out_valid_r, out_valid_nxt;
  dfp_pkg::record_t            rec_r;
  logic                        advance;
  logic                        step;
  logic                        emit;
  dfp_pkg::record_t            rec;

  // handshake
  assign advance   = !out_valid_r || out_tready;
  assign step      = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // input word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_valid_r <= 1'b1;
    end else if (step) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char_r <= in_tdata[dfp_pkg::CHAR_W-1:0];
      lo_r   <= in_tdata[dfp_pkg::CHAR_W+dfp_pkg::BOUND_W-1:dfp_pkg::CHAR_W];
      hi_r   <= in_tdata[dfp_pkg::CHAR_W+2*dfp_pkg::BOUND_W-1:
                         dfp_pkg::CHAR_W+dfp_pkg::BOUND_W];
      kind_r <= in_tuser;
    end
  end

  dfp_field u_field (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_i        (step),
    .character_i   (char_r),
    .kind_i        (kind_r),
    .lower_bound_i (lo_r),
    .upper_bound_i (hi_r),
    .emit_o        (emit),
    .record_o      (rec)
  );

  // result register
  assign out_valid_nxt = advance ? (step && emit) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && emit) begin
      rec_r <= rec;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(dfp_pkg::OUT_TDATA_W-dfp_pkg::VAL_W){1'b0}}, rec_r.field_value};
  assign out_tuser  = rec_r.status;
  assign out_tlast  = rec_r.last_of_line;

endmodule
